// ===== hw/rtl/ctbl_pkg.sv =====
// ctbl_pkg: shared constants, command and result codes, and the control
// structs between the sequencer and the scan compare unit.
// No dependencies.
package ctbl_pkg;

  localparam int SlotsDef = 16;

  localparam int CmdW    = 3;
  localparam int KeyW    = 64;
  localparam int TagW    = 32;
  localparam int StatusW = 32;
  localparam int BytesW  = 64;
  localparam int RcW     = 2;

  localparam logic [CmdW-1:0] CmdAdd     = 3'd0;
  localparam logic [CmdW-1:0] CmdDeliver = 3'd1;
  localparam logic [CmdW-1:0] CmdGet     = 3'd2;
  localparam logic [CmdW-1:0] CmdWaiter  = 3'd3;
  localparam logic [CmdW-1:0] CmdRemove  = 3'd4;

  localparam logic [RcW-1:0] RcDone    = 2'd0;
  localparam logic [RcW-1:0] RcFailed  = 2'd1;
  localparam logic [RcW-1:0] RcPending = 2'd2;

  // Index width for a table of n entries, never below one bit.
  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

  typedef struct packed {
    logic start;  // clear hit and free trackers for a new request
    logic check;  // compare the slot presented this cycle
  } scan_ctl_t;

  typedef struct packed {
    logic hit;    // an in-use slot matched the key
    logic free;   // a free slot was seen
  } scan_res_t;

endpackage

// ===== hw/rtl/ctbl_ram.sv =====
// ctbl_ram: generic single-write, single-read RAM with registered read data.
// Depends on ctbl_pkg for the address width helper.
module ctbl_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = ctbl_pkg::idx_w(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/ctbl_scan.sv =====
// ctbl_scan: shared key comparator for the slot scan; tracks the lowest
// matching in-use slot and the lowest free slot. Depends on ctbl_pkg.
module ctbl_scan #(
  parameter int Slots = ctbl_pkg::SlotsDef,
  localparam int IdxW = ctbl_pkg::idx_w(Slots)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ctbl_pkg::scan_ctl_t     ctl_i,
  input  logic [IdxW-1:0]         idx_i,
  input  logic                    used_i,
  input  logic [ctbl_pkg::KeyW-1:0] slot_key_i,
  input  logic [ctbl_pkg::KeyW-1:0] key_i,
  output ctbl_pkg::scan_res_t     res_o,
  output logic [IdxW-1:0]         hit_idx_o,
  output logic [IdxW-1:0]         free_idx_o
);

  ctbl_pkg::scan_res_t res_q, res_d;
  logic [IdxW-1:0] hit_idx_q, hit_idx_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic match;

  assign match = used_i && (slot_key_i == key_i);

  always_comb begin
    res_d      = res_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    if (ctl_i.start) begin
      res_d = '0;
    end else if (ctl_i.check) begin
      // keep only the lowest slot of each kind
      if (!res_q.hit && match) begin
        res_d.hit = 1'b1;
        hit_idx_d = idx_i;
      end
      if (!res_q.free && !used_i) begin
        res_d.free = 1'b1;
        free_idx_d = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q      <= '0;
      hit_idx_q  <= '0;
      free_idx_q <= '0;
    end else begin
      res_q      <= res_d;
      hit_idx_q  <= hit_idx_d;
      free_idx_q <= free_idx_d;
    end
  end

  assign res_o      = res_q;
  assign hit_idx_o  = hit_idx_q;
  assign free_idx_o = free_idx_q;

endmodule

// ===== hw/rtl/transfer_cookie_table_top.sv =====
// transfer_cookie_table_top: key-addressed table of transfer slots; uses ctbl_pkg,
// ctbl_ram and ctbl_scan. Each request walks the states StScan, StAct and StFin: the
// scan reads every slot through the key RAM read port into the shared comparator,
// StAct is the update state and StFin the result state. A new request is taken only
// in StIdle, after the last one has left StFin; a stalled result holds the block in StFin.
// Reset clears the in-use and finished marks and the control state; RAM needs no clearing.
module transfer_cookie_table_top #(
  parameter int Slots = ctbl_pkg::SlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // request channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ctbl_pkg::CmdW-1:0]     command_i,
  input  logic [ctbl_pkg::KeyW-1:0]     key_i,
  input  logic [ctbl_pkg::TagW-1:0]     waiter_tag_i,
  input  logic [ctbl_pkg::StatusW-1:0]  status_in_i,
  input  logic [ctbl_pkg::BytesW-1:0]   byte_count_in_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ctbl_pkg::RcW-1:0]      result_code_o,
  output logic [ctbl_pkg::StatusW-1:0]  status_out_o,
  output logic [ctbl_pkg::BytesW-1:0]   byte_count_out_o,
  output logic [ctbl_pkg::TagW-1:0]     waiter_out_o
);

  localparam int IdxW  = ctbl_pkg::idx_w(Slots);
  localparam int CntW  = $clog2(Slots + 1);
  localparam int KramW = ctbl_pkg::KeyW + ctbl_pkg::TagW;
  localparam int DramW = ctbl_pkg::StatusW + ctbl_pkg::BytesW;

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StAct,
    StFin
  } state_e;

  state_e state_q, state_d;

  // request held for the whole scan
  logic [ctbl_pkg::CmdW-1:0]    cmd_q;
  logic [ctbl_pkg::KeyW-1:0]    key_q;
  logic [ctbl_pkg::TagW-1:0]    tag_q;
  logic [ctbl_pkg::StatusW-1:0] st_q;
  logic [ctbl_pkg::BytesW-1:0]  nb_q;

  // scan address counter and the compare stage behind the RAM read
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            chk_vld_q, chk_vld_d;
  logic [IdxW-1:0] chk_idx_q, chk_idx_d;

  logic [Slots-1:0] used_q, used_d;
  logic [Slots-1:0] fin_q, fin_d;

  // output register
  logic                         out_valid_q, out_valid_d;
  logic [ctbl_pkg::RcW-1:0]     rc_q, rc_d;
  logic [ctbl_pkg::StatusW-1:0] st_out_q, st_out_d;
  logic [ctbl_pkg::BytesW-1:0]  nb_out_q, nb_out_d;
  logic [ctbl_pkg::TagW-1:0]    w_out_q, w_out_d;

  logic in_fire, out_load;
  logic add_ok, deliver_ok, remove_ok;

  ctbl_pkg::scan_ctl_t scan_ctl;
  ctbl_pkg::scan_res_t scan_res;
  logic [IdxW-1:0]     hit_idx, free_idx;

  logic             kram_we;
  logic [IdxW-1:0]  kram_raddr;
  logic [KramW-1:0] kram_rdata;
  logic             dram_we;
  logic [IdxW-1:0]  dram_waddr;
  logic [DramW-1:0] dram_wdata;
  logic [DramW-1:0] dram_rdata;

  assign in_ready_o = (state_q == StIdle);
  assign in_fire    = in_valid_i && in_ready_o;

  // Key and waiter share one RAM word; status and byte count share another.
  assign kram_we    = (state_q == StAct) && add_ok;
  assign kram_raddr = (state_q == StScan) ? cnt_q[IdxW-1:0] : hit_idx;

  ctbl_ram #(
    .Width(KramW),
    .Depth(Slots)
  ) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (kram_we),
    .waddr_i(free_idx),
    .wdata_i({key_q, tag_q}),
    .raddr_i(kram_raddr),
    .rdata_o(kram_rdata)
  );

  // Add zeroes status and byte count; deliver records them.
  assign dram_we    = (state_q == StAct) && (add_ok || deliver_ok);
  assign dram_waddr = add_ok ? free_idx : hit_idx;
  assign dram_wdata = add_ok ? '0 : {st_q, nb_q};

  ctbl_ram #(
    .Width(DramW),
    .Depth(Slots)
  ) u_data_ram (
    .clk_i  (clk_i),
    .we_i   (dram_we),
    .waddr_i(dram_waddr),
    .wdata_i(dram_wdata),
    .raddr_i(hit_idx),
    .rdata_o(dram_rdata)
  );

  assign scan_ctl.start = in_fire;
  assign scan_ctl.check = chk_vld_q;

  ctbl_scan #(
    .Slots(Slots)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (scan_ctl),
    .idx_i     (chk_idx_q),
    .used_i    (used_q[chk_idx_q]),
    .slot_key_i(kram_rdata[KramW-1 -: ctbl_pkg::KeyW]),
    .key_i     (key_q),
    .res_o     (scan_res),
    .hit_idx_o (hit_idx),
    .free_idx_o(free_idx)
  );

  // Decisions hold steady from the update cycle through the result cycle.
  assign add_ok     = (cmd_q == ctbl_pkg::CmdAdd) && (key_q != '0) &&
                      !scan_res.hit && scan_res.free;
  assign deliver_ok = (cmd_q == ctbl_pkg::CmdDeliver) && scan_res.hit;
  assign remove_ok  = (cmd_q == ctbl_pkg::CmdRemove) && scan_res.hit;

  assign out_load = (state_q == StFin) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    chk_vld_d = 1'b0;
    chk_idx_d = chk_idx_q;
    used_d    = used_q;
    fin_d     = fin_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          cnt_d   = '0;
          state_d = StScan;
        end
      end
      StScan: begin
        // issue one slot address a cycle; compare it the next cycle
        if (cnt_q < CntW'(Slots)) begin
          chk_vld_d = 1'b1;
          chk_idx_d = cnt_q[IdxW-1:0];
          cnt_d     = cnt_q + CntW'(1);
        end else begin
          state_d = StAct;
        end
      end
      StAct: begin
        if (add_ok) begin
          used_d[free_idx] = 1'b1;
          fin_d[free_idx]  = 1'b0;
        end
        if (deliver_ok) begin
          fin_d[hit_idx] = 1'b1;
        end
        if (remove_ok) begin
          used_d[hit_idx] = 1'b0;
          fin_d[hit_idx]  = 1'b0;
        end
        state_d = StFin;
      end
      StFin: begin
        // hold until the output register frees up
        if (out_load) begin
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // Build the result beat from the scan outcome and the RAM read data.
  always_comb begin
    rc_d     = ctbl_pkg::RcFailed;
    st_out_d = '0;
    nb_out_d = '0;
    w_out_d  = '0;
    case (cmd_q)
      ctbl_pkg::CmdAdd: begin
        if (add_ok) rc_d = ctbl_pkg::RcDone;
      end
      ctbl_pkg::CmdDeliver: begin
        if (deliver_ok) rc_d = ctbl_pkg::RcDone;
      end
      ctbl_pkg::CmdGet: begin
        if (scan_res.hit) begin
          if (fin_q[hit_idx]) begin
            rc_d     = ctbl_pkg::RcDone;
            st_out_d = dram_rdata[DramW-1 -: ctbl_pkg::StatusW];
            nb_out_d = dram_rdata[ctbl_pkg::BytesW-1:0];
          end else begin
            rc_d = ctbl_pkg::RcPending;
          end
        end
      end
      ctbl_pkg::CmdWaiter: begin
        if (scan_res.hit) begin
          rc_d    = ctbl_pkg::RcDone;
          w_out_d = kram_rdata[ctbl_pkg::TagW-1:0];
        end
      end
      ctbl_pkg::CmdRemove: begin
        if (remove_ok) rc_d = ctbl_pkg::RcDone;
      end
      default: rc_d = ctbl_pkg::RcFailed;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      chk_vld_q   <= 1'b0;
      chk_idx_q   <= '0;
      used_q      <= '0;
      fin_q       <= '0;
      out_valid_q <= 1'b0;
      rc_q        <= '0;
      st_out_q    <= '0;
      nb_out_q    <= '0;
      w_out_q     <= '0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      chk_vld_q   <= chk_vld_d;
      chk_idx_q   <= chk_idx_d;
      used_q      <= used_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
      // load the result beat as the result cycle ends
      if (out_load) begin
        rc_q     <= rc_d;
        st_out_q <= st_out_d;
        nb_out_q <= nb_out_d;
        w_out_q  <= w_out_d;
      end
    end
  end

  // Request registers: capture the beat as it is accepted.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      cmd_q <= command_i;
      key_q <= key_i;
      tag_q <= waiter_tag_i;
      st_q  <= status_in_i;
      nb_q  <= byte_count_in_i;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_code_o    = rc_q;
  assign status_out_o     = st_out_q;
  assign byte_count_out_o = nb_out_q;
  assign waiter_out_o     = w_out_q;

endmodule

// ===== sim/transfer_cookie_table_top_tb.sv =====
// transfer_cookie_table_top_tb: self-checking bench for the transfer cookie table.
// Drives command beats and checks every result beat against a directed reply or a mirror of the slot table.
// Depends on ctbl_pkg and transfer_cookie_table_top.
module transfer_cookie_table_top_tb;

  // Local names for the package widths and codes.
  localparam int CmdW    = ctbl_pkg::CmdW;
  localparam int KeyW    = ctbl_pkg::KeyW;
  localparam int TagW    = ctbl_pkg::TagW;
  localparam int StatusW = ctbl_pkg::StatusW;
  localparam int BytesW  = ctbl_pkg::BytesW;
  localparam int RcW     = ctbl_pkg::RcW;

  localparam logic [CmdW-1:0] CmdAdd     = ctbl_pkg::CmdAdd;
  localparam logic [CmdW-1:0] CmdDeliver = ctbl_pkg::CmdDeliver;
  localparam logic [CmdW-1:0] CmdGet     = ctbl_pkg::CmdGet;
  localparam logic [CmdW-1:0] CmdWaiter  = ctbl_pkg::CmdWaiter;
  localparam logic [CmdW-1:0] CmdRemove  = ctbl_pkg::CmdRemove;

  localparam logic [RcW-1:0] RcDone    = ctbl_pkg::RcDone;
  localparam logic [RcW-1:0] RcFailed  = ctbl_pkg::RcFailed;
  localparam logic [RcW-1:0] RcPending = ctbl_pkg::RcPending;

  localparam int Slots       = ctbl_pkg::SlotsDef;
  localparam int LatencyCyc  = Slots + 3;
  localparam int RandomBeats = 450;
  localparam int BatchLen    = 50;
  localparam int PoolSize    = 20;
  localparam int HoldCycles  = 300;
  localparam int HoldAfter   = 60;
  localparam int LimitCycles = 200000;
  localparam int IdlePct     = 19;

  // Command codes the block must refuse.
  localparam logic [CmdW-1:0] CmdRsvd5 = 3'd5;
  localparam logic [CmdW-1:0] CmdRsvd6 = 3'd6;
  localparam logic [CmdW-1:0] CmdRsvd7 = 3'd7;

  localparam logic [63:0] Zero64 = '0;
  localparam logic [63:0] Ones64 = '1;
  localparam logic [31:0] Zero32 = '0;
  localparam logic [31:0] Ones32 = '1;

  typedef struct packed {
    logic [RcW-1:0]     rc;
    logic [StatusW-1:0] status;
    logic [BytesW-1:0]  bytes;
    logic [TagW-1:0]    waiter;
  } cookie_reply_t;

  typedef struct packed {
    logic               typed;
    logic [CmdW-1:0]    cmd;
    logic [KeyW-1:0]    key;
    logic [TagW-1:0]    tag;
    logic [StatusW-1:0] status;
    logic [BytesW-1:0]  bytes;
    cookie_reply_t      reply;
  } cookie_req_row_t;

  localparam int NumDir = 24;

  // Directed opening: rows with typed = 1 carry the reply to expect; the rest
  // take their reply from the table mirror.
  cookie_req_row_t dir_rows [NumDir] = '{
    // empty table, zero key, extremes
    '{1'b1, CmdGet,     64'd5,  Zero32, Zero32, Zero64, '{RcFailed,  Zero32, Zero64, Zero32}},
    '{1'b1, CmdAdd,     Zero64, Ones32, Zero32, Zero64, '{RcFailed,  Zero32, Zero64, Zero32}},
    '{1'b1, CmdAdd,     Ones64, Ones32, Zero32, Zero64, '{RcDone,    Zero32, Zero64, Zero32}},
    '{1'b1, CmdAdd,     Ones64, Zero32, Zero32, Zero64, '{RcFailed,  Zero32, Zero64, Zero32}},
    '{1'b1, CmdGet,     Ones64, Zero32, Zero32, Zero64, '{RcPending, Zero32, Zero64, Zero32}},
    '{1'b1, CmdWaiter,  Ones64, Zero32, Zero32, Zero64, '{RcDone,    Zero32, Zero64, Ones32}},
    '{1'b1, CmdDeliver, Ones64, Zero32, Ones32, Ones64, '{RcDone,    Zero32, Zero64, Zero32}},
    '{1'b1, CmdGet,     Ones64, Zero32, Zero32, Zero64, '{RcDone,    Ones32, Ones64, Zero32}},
    // second deliver overwrites a finished entry
    '{1'b1, CmdDeliver, Ones64, Ones32, Zero32, Zero64, '{RcDone,    Zero32, Zero64, Zero32}},
    '{1'b1, CmdGet,     Ones64, Ones32, Ones32, Ones64, '{RcDone,    Zero32, Zero64, Zero32}},
    // reserved commands
    '{1'b1, CmdRsvd5,   Ones64, Ones32, Ones32, Ones64, '{RcFailed,  Zero32, Zero64, Zero32}},
    '{1'b1, CmdRsvd6,   Ones64, Ones32, Ones32, Ones64, '{RcFailed,  Zero32, Zero64, Zero32}},
    '{1'b1, CmdRsvd7,   Ones64, Ones32, Ones32, Ones64, '{RcFailed,  Zero32, Zero64, Zero32}},
    // remove, then remove, deliver and waiter on that key miss; then work on a new key
    '{1'b1, CmdRemove,  Ones64, Zero32, Zero32, Zero64, '{RcDone,    Zero32, Zero64, Zero32}},
    '{1'b1, CmdRemove,  Ones64, Zero32, Zero32, Zero64, '{RcFailed,  Zero32, Zero64, Zero32}},
    '{1'b1, CmdDeliver, Ones64, Zero32, Ones32, Ones64, '{RcFailed,  Zero32, Zero64, Zero32}},
    '{1'b1, CmdWaiter,  Ones64, Ones32, Zero32, Zero64, '{RcFailed,  Zero32, Zero64, Zero32}},
    '{1'b1, CmdAdd,     64'd1,  Zero32, Zero32, Zero64, '{RcDone,    Zero32, Zero64, Zero32}},
    '{1'b1, CmdWaiter,  64'd1,  Ones32, Zero32, Zero64, '{RcDone,    Zero32, Zero64, Zero32}},
    '{1'b0, CmdDeliver, 64'd1,  Zero32, 32'h8000_0001, 64'h8000_0000_0000_0001, '0},
    '{1'b0, CmdGet,     64'd1,  Zero32, Zero32, Zero64, '0},
    // re-add after remove starts unfinished
    '{1'b1, CmdRemove,  64'd1,  Zero32, Zero32, Zero64, '{RcDone,    Zero32, Zero64, Zero32}},
    '{1'b1, CmdAdd,     64'd1,  32'hA5A5_5A5A, Zero32, Zero64, '{RcDone, Zero32, Zero64, Zero32}},
    '{1'b1, CmdGet,     64'd1,  Zero32, Zero32, Zero64, '{RcPending, Zero32, Zero64, Zero32}}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               req_valid = 1'b0;
  logic               req_ready;
  logic [CmdW-1:0]    req_cmd = CmdAdd;
  logic [KeyW-1:0]    req_key = '0;
  logic [TagW-1:0]    req_tag = '0;
  logic [StatusW-1:0] req_status = '0;
  logic [BytesW-1:0]  req_bytes = '0;
  logic               rsp_valid;
  logic               rsp_ready = 1'b0;
  logic [RcW-1:0]     rsp_rc;
  logic [StatusW-1:0] rsp_status;
  logic [BytesW-1:0]  rsp_bytes;
  logic [TagW-1:0]    rsp_waiter;

  transfer_cookie_table_top #(.Slots(Slots)) DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (req_valid),
    .in_ready_o       (req_ready),
    .command_i        (req_cmd),
    .key_i            (req_key),
    .waiter_tag_i     (req_tag),
    .status_in_i      (req_status),
    .byte_count_in_i  (req_bytes),
    .out_valid_o      (rsp_valid),
    .out_ready_i      (rsp_ready),
    .result_code_o    (rsp_rc),
    .status_out_o     (rsp_status),
    .byte_count_out_o (rsp_bytes),
    .waiter_out_o     (rsp_waiter)
  );

  // Mirror of the slot table; starts empty since reset clears the in-use marks.
  logic [KeyW-1:0]    mirror_key      [Slots] = '{default: '0};
  logic [TagW-1:0]    mirror_waiter   [Slots] = '{default: '0};
  logic [StatusW-1:0] mirror_status   [Slots] = '{default: '0};
  logic [BytesW-1:0]  mirror_bytes    [Slots] = '{default: '0};
  logic               mirror_finished [Slots] = '{default: 1'b0};
  logic               mirror_used     [Slots] = '{default: 1'b0};

  cookie_reply_t replies_due[$];
  int            mismatches = 0;
  int            replies_seen = 0;
  bit            calm = 1'b0;

  // Apply one request to the mirror and return the reply it must produce.
  function automatic cookie_reply_t cookie_table_apply(
    input logic [CmdW-1:0]    cmd,
    input logic [KeyW-1:0]    key,
    input logic [TagW-1:0]    tag,
    input logic [StatusW-1:0] status,
    input logic [BytesW-1:0]  bytes
  );
    cookie_reply_t r;
    int            hit;
    int            spare;
    r     = '0;
    r.rc  = RcFailed;
    hit   = -1;
    spare = -1;
    // scan downward so the lowest matching and lowest free slot win
    for (int i = Slots - 1; i >= 0; i--) begin
      if (mirror_used[i] && mirror_key[i] == key) hit = i;
      if (!mirror_used[i]) spare = i;
    end
    case (cmd)
      CmdAdd: begin
        if (key != '0 && hit < 0 && spare >= 0) begin
          mirror_key[spare]      = key;
          mirror_waiter[spare]   = tag;
          mirror_status[spare]   = '0;
          mirror_bytes[spare]    = '0;
          mirror_finished[spare] = 1'b0;
          mirror_used[spare]     = 1'b1;
          r.rc = RcDone;
        end
      end
      CmdDeliver: begin
        if (hit >= 0) begin
          mirror_status[hit]   = status;
          mirror_bytes[hit]    = bytes;
          mirror_finished[hit] = 1'b1;
          r.rc = RcDone;
        end
      end
      CmdGet: begin
        if (hit >= 0) begin
          if (!mirror_finished[hit]) begin
            r.rc = RcPending;
          end else begin
            r.status = mirror_status[hit];
            r.bytes  = mirror_bytes[hit];
            r.rc     = RcDone;
          end
        end
      end
      CmdWaiter: begin
        if (hit >= 0) begin
          r.waiter = mirror_waiter[hit];
          r.rc     = RcDone;
        end
      end
      CmdRemove: begin
        if (hit >= 0) begin
          mirror_key[hit]      = '0;
          mirror_waiter[hit]   = '0;
          mirror_status[hit]   = '0;
          mirror_bytes[hit]    = '0;
          mirror_finished[hit] = 1'b0;
          mirror_used[hit]     = 1'b0;
          r.rc = RcDone;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatches++;
    $display("tb: mismatch on %s: got %h, want %h", what, got, want);
  endtask

  // Offer one request beat; called right after a rising edge, returns at the
  // edge that accepts it. Valid is only lowered when a gap is taken.
  task automatic send_cookie_req(input logic typed, input cookie_reply_t typed_reply,
                                 input logic [CmdW-1:0] cmd, input logic [KeyW-1:0] key,
                                 input logic [TagW-1:0] tag,
                                 input logic [StatusW-1:0] status,
                                 input logic [BytesW-1:0] bytes);
    cookie_reply_t mirrored;
    // idle the sender now and then; long gaps land on every phase of the scan
    if (!calm && $urandom_range(0, 99) < IdlePct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk_i);
    end
    req_valid  <= 1'b1;
    req_cmd    <= cmd;
    req_key    <= key;
    req_tag    <= tag;
    req_status <= status;
    req_bytes  <= bytes;
    // sample ready mid-cycle, clear of the edge
    do @(negedge clk_i); while (!req_ready);
    @(posedge clk_i);
    mirrored = cookie_table_apply(cmd, key, tag, status, bytes);
    replies_due.push_back(typed ? typed_reply : mirrored);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the replies never drain.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LimitCycles) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("tb: failure");
    $finish;
  end

  // Result side: random stalls, one long hold-off so the table backs up and
  // stalls the request side, and no stalls while the calm batch runs.
  initial begin : result_side
    bit held;
    held = 1'b0;
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      @(posedge clk_i);
      if (!held && replies_seen >= HoldAfter) begin
        held = 1'b1;
        rsp_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else begin
        rsp_ready <= calm || ($urandom_range(0, 99) >= IdlePct);
      end
    end
  end

  // Check each result beat, field by field, against the oldest reply due.
  always @(negedge clk_i) begin : check_replies
    cookie_reply_t want;
    if (rst_ni && rsp_valid && rsp_ready) begin
      replies_seen++;
      if (replies_due.size() == 0) begin
        report_mismatch("result beat with nothing due", 64'(rsp_rc), '0);
      end else begin
        want = replies_due.pop_front();
        if (rsp_rc !== want.rc) report_mismatch("result_code", 64'(rsp_rc), 64'(want.rc));
        if (rsp_status !== want.status) begin
          report_mismatch("status_out", 64'(rsp_status), 64'(want.status));
        end
        if (rsp_bytes !== want.bytes) report_mismatch("byte_count_out", rsp_bytes, want.bytes);
        if (rsp_waiter !== want.waiter) begin
          report_mismatch("waiter_out", 64'(rsp_waiter), 64'(want.waiter));
        end
      end
    end
  end

  initial begin : request_side
    logic [KeyW-1:0] key_pool [PoolSize];
    logic [CmdW-1:0] cmd;
    logic [KeyW-1:0] key;
    int              mode;
    int              pick;
    int              add_lim;
    int              dlv_lim;
    int              get_lim;
    int              wtr_lim;
    int              fill_ptr;

    fill_ptr = 0;
    // Key pool is a little larger than the table, so fills hit a full table
    // and a few lookups still miss.
    for (int i = 0; i < PoolSize; i++) begin
      key_pool[i] = {$urandom, $urandom};
      if (key_pool[i] == '0) key_pool[i] = 64'd2;
    end

    // Hold reset low from the start, then release it once.
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumDir; r++) begin
      send_cookie_req(dir_rows[r].typed, dir_rows[r].reply, dir_rows[r].cmd,
                      dir_rows[r].key, dir_rows[r].tag, dir_rows[r].status,
                      dir_rows[r].bytes);
    end

    // Random batches rotate through fill, mixed and drain profiles; the fourth
    // batch runs with no idling on either side.
    for (int n = 0; n < RandomBeats; n++) begin
      mode = (n / BatchLen) % 3;
      calm = ((n / BatchLen) == 3);
      case (mode)
        0:       begin add_lim = 60; dlv_lim = 75; get_lim = 85; wtr_lim = 92; end
        1:       begin add_lim = 30; dlv_lim = 50; get_lim = 70; wtr_lim = 85; end
        default: begin add_lim = 15; dlv_lim = 30; get_lim = 45; wtr_lim = 55; end
      endcase
      pick = $urandom_range(0, 99);
      if (pick < add_lim)      cmd = CmdAdd;
      else if (pick < dlv_lim) cmd = CmdDeliver;
      else if (pick < get_lim) cmd = CmdGet;
      else if (pick < wtr_lim) cmd = CmdWaiter;
      else                     cmd = CmdRemove;
      if (cmd == CmdAdd && mode == 0) begin
        // walk the pool so a fill batch really fills the table
        key = key_pool[fill_ptr];
        fill_ptr = (fill_ptr + 1) % PoolSize;
      end else begin
        key = key_pool[$urandom_range(0, PoolSize - 1)];
      end
      // A few noise beats: reserved commands, zero-key adds, unknown keys.
      if ($urandom_range(0, 99) < 6) begin
        case ($urandom_range(0, 4))
          0:       cmd = CmdRsvd5;
          1:       cmd = CmdRsvd6;
          2:       cmd = CmdRsvd7;
          3:       begin cmd = CmdAdd; key = '0; end
          default: key = {$urandom, $urandom};
        endcase
      end
      send_cookie_req(1'b0, '0, cmd, key, $urandom, $urandom, {$urandom, $urandom});
    end
    calm = 1'b0;
    req_valid <= 1'b0;

    // Drain: wait for every reply due, then run on to catch any stray beat.
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (2 * LatencyCyc) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
